@@ rtl/idct_pkg.sv @@
package idct_pkg;

	localparam int W_COEF  = 16;
	localparam int W_STORE = 24;
	localparam int W_PIX   = 8;
	localparam int N_LANE  = 8;
	localparam int W_ROW   = $clog2(N_LANE);
	localparam int N_STAGE = 4;

	typedef logic signed [47:0] acc_t;
	typedef logic signed [W_STORE-1:0] store_t;

	localparam acc_t KC1 = 48'sd2841;
	localparam acc_t KC2 = 48'sd2676;
	localparam acc_t KC3 = 48'sd2408;
	localparam acc_t KC5 = 48'sd1609;
	localparam acc_t KC6 = 48'sd1108;
	localparam acc_t KC7 = 48'sd565;
	localparam acc_t KR2 = 48'sd181;
	localparam acc_t COL_BIAS   = 48'sd8192;
	localparam acc_t PIX_OFFSET = 48'sd128;

	typedef enum logic [1:0] {
		ST_ROWS,
		ST_FLUSH,
		ST_COL,
		ST_DRAIN
	} st_t;

	function automatic logic [W_PIX-1:0] clip8(acc_t v);
		logic [W_PIX-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > 48'sd255)
			r = '1;
		else
			r = v[W_PIX-1:0];
		return r;
	endfunction

	function automatic store_t sat24(acc_t v);
		store_t r;
		if (v > 48'sd8388607)
			r = 24'sh7FFFFF;
		else if (v < -48'sd8388608)
			r = 24'sh800000;
		else
			r = v[W_STORE-1:0];
		return r;
	endfunction

endpackage

@@ rtl/idct_coef_if.sv @@
interface idct_coef_if;
	import idct_pkg::*;
	logic valid;
	logic ready;
	logic signed [W_COEF-1:0] coef_0;
	logic signed [W_COEF-1:0] coef_1;
	logic signed [W_COEF-1:0] coef_2;
	logic signed [W_COEF-1:0] coef_3;
	logic signed [W_COEF-1:0] coef_4;
	logic signed [W_COEF-1:0] coef_5;
	logic signed [W_COEF-1:0] coef_6;
	logic signed [W_COEF-1:0] coef_7;

	modport source (output valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6,
		coef_7, input ready);
	modport sink (input valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6,
		coef_7, output ready);
endinterface

@@ rtl/idct_pix_if.sv @@
interface idct_pix_if;
	import idct_pkg::*;
	logic valid;
	logic ready;
	logic [W_PIX-1:0] pixel_0;
	logic [W_PIX-1:0] pixel_1;
	logic [W_PIX-1:0] pixel_2;
	logic [W_PIX-1:0] pixel_3;
	logic [W_PIX-1:0] pixel_4;
	logic [W_PIX-1:0] pixel_5;
	logic [W_PIX-1:0] pixel_6;
	logic [W_PIX-1:0] pixel_7;
	logic [W_ROW-1:0] out_row;
	logic block_done;

	modport source (output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
		pixel_6, pixel_7, out_row, block_done, input ready);
	modport sink (input valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
		pixel_6, pixel_7, out_row, block_done, output ready);
endinterface

@@ rtl/idct_1d.sv @@
// Four-stage 1-D integer IDCT core; COL_PASS selects column scaling and clipping.
module idct_1d import idct_pkg::*; #(
	parameter bit COL_PASS = 1'b0
) (
	input  logic   clk,
	input  store_t d [N_LANE],
	output store_t o [N_LANE]
);

	localparam int SH_MUL = COL_PASS ? 3 : 0;
	localparam int SH_OUT = COL_PASS ? 14 : 8;

	acc_t e [N_LANE];
	logic dc_only;
	store_t dcv;

	acc_t x0_s1, x1_s1, m8a_s1, m4_s1, m5_s1, m8b_s1, m6_s1, m7_s1, m1_s1, m2_s1, m3_s1;
	logic dc_s1, dc_s2, dc_s3;
	store_t dcv_s1, dcv_s2, dcv_s3;
	acc_t b0_s2, b1_s2, b3_s2, b6_s2, b7_s2, b8_s2, sa_s2, sd_s2;
	acc_t b0_s3, b1_s3, b3_s3, b6_s3, b7_s3, b8_s3, c2_s3, c4_s3;
	acc_t y [N_LANE];

	always_comb begin
		for (int k = 0; k < N_LANE; k++)
			e[k] = acc_t'(d[k]);
		dc_only = (d[1] == 0) && (d[2] == 0) && (d[3] == 0) && (d[4] == 0) &&
			(d[5] == 0) && (d[6] == 0) && (d[7] == 0);
		if (COL_PASS)
			dcv = store_t'({16'd0, clip8(((e[0] + 48'sd32) >>> 6) + PIX_OFFSET)});
		else
			dcv = store_t'(e[0] <<< 3);
	end

	always_ff @(posedge clk) begin
		acc_t rnd;
		rnd = COL_PASS ? 48'sd4 : 48'sd0;
		if (COL_PASS) begin
			x0_s1 <= (e[0] <<< 8) + COL_BIAS;
			x1_s1 <= e[4] <<< 8;
		end else begin
			x0_s1 <= (e[0] <<< 11) + 48'sd128;
			x1_s1 <= e[4] <<< 11;
		end
		m8a_s1 <= KC7 * (e[1] + e[7]) + rnd;
		m4_s1  <= (KC1 - KC7) * e[1];
		m5_s1  <= (KC1 + KC7) * e[7];
		m8b_s1 <= KC3 * (e[5] + e[3]) + rnd;
		m6_s1  <= (KC3 - KC5) * e[5];
		m7_s1  <= (KC3 + KC5) * e[3];
		m1_s1  <= KC6 * (e[2] + e[6]) + rnd;
		m2_s1  <= (KC2 + KC6) * e[6];
		m3_s1  <= (KC2 - KC6) * e[2];
		dc_s1  <= dc_only;
		dcv_s1 <= dcv;
	end

	// butterflies after the odd/even rotations
	always_ff @(posedge clk) begin
		acc_t a0, a2, a3, a4, a5, a6, a7, a8, b4, b5;
		a4 = (m8a_s1 + m4_s1) >>> SH_MUL;
		a5 = (m8a_s1 - m5_s1) >>> SH_MUL;
		a6 = (m8b_s1 - m6_s1) >>> SH_MUL;
		a7 = (m8b_s1 - m7_s1) >>> SH_MUL;
		a2 = (m1_s1 - m2_s1) >>> SH_MUL;
		a3 = (m1_s1 + m3_s1) >>> SH_MUL;
		a8 = x0_s1 + x1_s1;
		a0 = x0_s1 - x1_s1;
		b4 = a4 - a6;
		b5 = a5 - a7;
		b1_s2 <= a4 + a6;
		b6_s2 <= a5 + a7;
		b7_s2 <= a8 + a3;
		b8_s2 <= a8 - a3;
		b3_s2 <= a0 + a2;
		b0_s2 <= a0 - a2;
		sa_s2 <= b4 + b5;
		sd_s2 <= b4 - b5;
		dc_s2  <= dc_s1;
		dcv_s2 <= dcv_s1;
	end

	always_ff @(posedge clk) begin
		c2_s3 <= (KR2 * sa_s2 + 48'sd128) >>> 8;
		c4_s3 <= (KR2 * sd_s2 + 48'sd128) >>> 8;
		b0_s3 <= b0_s2;
		b1_s3 <= b1_s2;
		b3_s3 <= b3_s2;
		b6_s3 <= b6_s2;
		b7_s3 <= b7_s2;
		b8_s3 <= b8_s2;
		dc_s3  <= dc_s2;
		dcv_s3 <= dcv_s2;
	end

	always_comb begin
		y[0] = b7_s3 + b1_s3;
		y[1] = b3_s3 + c2_s3;
		y[2] = b0_s3 + c4_s3;
		y[3] = b8_s3 + b6_s3;
		y[4] = b8_s3 - b6_s3;
		y[5] = b0_s3 - c4_s3;
		y[6] = b3_s3 - c2_s3;
		y[7] = b7_s3 - b1_s3;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_LANE; k++) begin
			if (dc_s3)
				o[k] <= dcv_s3;
			else if (COL_PASS)
				o[k] <= store_t'({16'd0, clip8((y[k] >>> SH_OUT) + PIX_OFFSET)});
			else
				o[k] <= sat24(y[k] >>> SH_OUT);
		end
	end

endmodule

@@ rtl/idct_8x8_integer.sv @@
// Path: after the eighth row transfer the block passes through the 4-stage row core,
//   the store write, the 4-stage column lanes and the output buffer load.
// Throughput: one coefficient row per cycle for rows 0..7, then the block is closed
//   for input until the eight pixel rows drain.
// Reset: arst_n clears the row counter, the state and all valid bits; the row store
//   and data pipelines are not reset.
module idct_8x8_integer import idct_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	idct_coef_if.sink    coef,
	idct_pix_if.source   pix
);

	st_t state_q, state_d;
	logic [W_ROW-1:0] rows_q;       // rows of the current block taken so far
	logic [W_ROW-1:0] orow_q;       // pixel row being offered
	logic [N_STAGE-1:0] rvld_s;     // row core valid, one bit per stage
	logic [N_STAGE-1:0] cvld_s;     // column lanes valid
	logic [W_ROW-1:0] ridx_s [N_STAGE];
	logic in_xfer, out_xfer, row_empty, col_go;

	store_t row_in [N_LANE];
	store_t row_out [N_LANE];
	store_t store_q [N_LANE][N_LANE];   // [row][column] of row-pass results
	store_t col_in [N_LANE][N_LANE];    // [lane][element]
	store_t col_out [N_LANE][N_LANE];   // [lane][pixel row]
	logic [W_PIX-1:0] pix_q [N_LANE][N_LANE]; // [row][column]

	assign in_xfer   = coef.valid && coef.ready;
	assign out_xfer  = pix.valid && pix.ready;
	assign row_empty = (rvld_s == '0);
	assign col_go    = (state_q == ST_FLUSH) && row_empty;

	// Row pass: one core, sign-extended coefficients enter straight from the port.
	always_comb begin
		row_in[0] = store_t'(coef.coef_0);
		row_in[1] = store_t'(coef.coef_1);
		row_in[2] = store_t'(coef.coef_2);
		row_in[3] = store_t'(coef.coef_3);
		row_in[4] = store_t'(coef.coef_4);
		row_in[5] = store_t'(coef.coef_5);
		row_in[6] = store_t'(coef.coef_6);
		row_in[7] = store_t'(coef.coef_7);
	end

	idct_1d #(.COL_PASS(1'b0)) u_row (
		.clk (clk),
		.d   (row_in),
		.o   (row_out)
	);

	// Track valid and destination row alongside the row core.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s <= '0;
			cvld_s <= '0;
		end else begin
			rvld_s <= {rvld_s[N_STAGE-2:0], in_xfer};
			cvld_s <= {cvld_s[N_STAGE-2:0], col_go};
		end
	end

	always_ff @(posedge clk) begin
		ridx_s[0] <= rows_q;
		for (int s = 1; s < N_STAGE; s++)
			ridx_s[s] <= ridx_s[s-1];
	end

	// Write a finished row into the store.
	always_ff @(posedge clk) begin
		if (rvld_s[N_STAGE-1]) begin
			for (int k = 0; k < N_LANE; k++)
				store_q[ridx_s[N_STAGE-1]][k] <= row_out[k];
		end
	end

	// Column pass: eight lanes, lane c takes column c of the store.
	always_comb begin
		for (int c = 0; c < N_LANE; c++)
			for (int i = 0; i < N_LANE; i++)
				col_in[c][i] = store_q[i][c];
	end

	for (genvar c = 0; c < N_LANE; c++) begin : g_lane
		idct_1d #(.COL_PASS(1'b1)) u_col (
			.clk (clk),
			.d   (col_in[c]),
			.o   (col_out[c])
		);
	end

	// Merge the lanes: transpose column results into the pixel-row buffer.
	always_ff @(posedge clk) begin
		if (cvld_s[N_STAGE-1]) begin
			for (int i = 0; i < N_LANE; i++)
				for (int c = 0; c < N_LANE; c++)
					pix_q[i][c] <= col_out[c][i][W_PIX-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ROWS;
			rows_q  <= '0;
			orow_q  <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer)
				rows_q <= rows_q + 1'b1;
			if (cvld_s[N_STAGE-1])
				orow_q <= '0;
			else if (out_xfer)
				orow_q <= orow_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ROWS: begin
				// close the block after its last row transfer
				if (in_xfer && (rows_q == W_ROW'(N_LANE - 1)))
					state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (row_empty)
					state_d = ST_COL;
			end
			ST_COL: begin
				if (cvld_s[N_STAGE-1])
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (out_xfer && (orow_q == W_ROW'(N_LANE - 1)))
					state_d = ST_ROWS;
			end
			default: state_d = ST_ROWS;
		endcase
	end

	assign coef.ready     = (state_q == ST_ROWS);
	assign pix.valid      = (state_q == ST_DRAIN);
	assign pix.out_row    = orow_q;
	assign pix.block_done = (orow_q == W_ROW'(N_LANE - 1));
	assign pix.pixel_0    = pix_q[orow_q][0];
	assign pix.pixel_1    = pix_q[orow_q][1];
	assign pix.pixel_2    = pix_q[orow_q][2];
	assign pix.pixel_3    = pix_q[orow_q][3];
	assign pix.pixel_4    = pix_q[orow_q][4];
	assign pix.pixel_5    = pix_q[orow_q][5];
	assign pix.pixel_6    = pix_q[orow_q][6];
	assign pix.pixel_7    = pix_q[orow_q][7];

endmodule

@@ rtl/idct_chk.sv @@
module idct_chk import idct_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [W_ROW-1:0] out_row,
	input logic             block_done
);

	// input closed while pixel rows drain
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input open while pixel rows pending");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (block_done == (out_row == W_ROW'(N_LANE - 1))))
		else $error("block_done not on last row");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !block_done) |=>
		(out_valid && (out_row == W_ROW'($past(out_row) + 1'b1))))
		else $error("pixel rows not consecutive");

	a_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && block_done) |=> (!out_valid && in_ready))
		else $error("block did not close after last row");

endmodule

bind idct_8x8_integer idct_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (coef.ready),
	.out_valid  (pix.valid),
	.out_ready  (pix.ready),
	.out_row    (pix.out_row),
	.block_done (pix.block_done)
);
